// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gpb_pkg.sv =====
`timescale 1ns / 1ps

package gpb_pkg;

   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned NUM_CHAN  = 4;
   localparam int unsigned PIX_W     = CHAN_W * NUM_CHAN;
   localparam int unsigned COORD_W   = 16;
   localparam int unsigned DIM_W     = 14;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [PIX_W-1:0]    TINT_RESET = 32'hFFFF_FFFF;
   localparam logic [CHAN_W-1:0]   CHAN_MAX   = 8'hFF;
   localparam logic [2*CHAN_W-1:0] ROUND_BIAS = 16'd128;

   // Register map of the configuration channel.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TINT        = 3'd0,
      CSR_WIDTH       = 3'd1,
      CSR_HEIGHT      = 3'd2,
      CSR_CLIP_LEFT   = 3'd3,
      CSR_CLIP_TOP    = 3'd4,
      CSR_CLIP_RIGHT  = 3'd5,
      CSR_CLIP_BOTTOM = 3'd6
   } csr_index_type;

   typedef enum logic {
      MODE_MONO  = 1'b0,
      MODE_EMOJI = 1'b1
   } mode_type;

   // Request payload as carried on tdata, first field in the highest bits.
   typedef struct packed {
      logic [PIX_W-1:0]          dest_pixel;
      logic [PIX_W-1:0]          source_value;
      logic signed [COORD_W-1:0] dest_y;
      logic signed [COORD_W-1:0] dest_x;
   } req_data_type;

   // Control handed from the coordinate check to the blend datapath.
   typedef struct packed {
      mode_type mode;
      logic     in_bounds;
   } blend_ctrl_type;

   // Multiply two 8-bit values and divide by 256 with rounding.
   function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] x,
                                                input logic [CHAN_W-1:0] y);
      logic [2*CHAN_W-1:0] prod;
      prod = x * y + ROUND_BIAS;
      return prod[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

// ===== rtl/glyph_pixel_blend_core.sv =====
`timescale 1ns / 1ps
// A request beat passes through the input register and then the result
// register before it leaves as a response beat. Throughput: one pixel per
// clock unless the response side stalls; every request yields exactly one response.
// Reset (synchronous, active high) empties both stages and restores the
// registers: tint all ones, target size and clip rectangle zero.

module glyph_pixel_blend_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [95:0]                          req_tdata,  // dest_x, dest_y, source_value, dest_pixel
   input  logic                                 req_tuser,  // mode
   // Response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,  // blended_pixel
   output logic                                 rsp_tuser,  // write_enable
   // Configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gpb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                          csr_data
);
   import gpb_pkg::*;

   logic [PIX_W-1:0]          tint_ff;
   logic [DIM_W-1:0]          width_ff;
   logic [DIM_W-1:0]          height_ff;
   logic signed [COORD_W-1:0] clip_left_ff;
   logic signed [COORD_W-1:0] clip_top_ff;
   logic signed [COORD_W-1:0] clip_right_ff;
   logic signed [COORD_W-1:0] clip_bottom_ff;

   logic          in_valid_ff;
   req_data_type  in_data_ff;
   mode_type      in_mode_ff;
   logic          out_valid_ff;
   logic [PIX_W-1:0] out_pixel_ff;
   logic          out_we_ff;

   logic          out_free;
   logic          advance;
   logic          in_target;
   logic          in_clip;
   blend_ctrl_type blend_ctrl;
   logic          blend_we;
   logic [PIX_W-1:0] blend_pixel;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff        <= TINT_RESET;
         width_ff       <= '0;
         height_ff      <= '0;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= '0;
         clip_bottom_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TINT:        tint_ff        <= csr_data;
            CSR_WIDTH:       width_ff       <= csr_data[DIM_W-1:0];
            CSR_HEIGHT:      height_ff      <= csr_data[DIM_W-1:0];
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_data[COORD_W-1:0];
            CSR_CLIP_TOP:    clip_top_ff    <= csr_data[COORD_W-1:0];
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_data[COORD_W-1:0];
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: the result register frees when its beat is taken,
   // and the input register moves on whenever the result register is free.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_data_type'(req_tdata);
         in_mode_ff <= mode_type'(req_tuser);
      end
   end

   // Bounds check against the target and the clip rectangle.
   always_comb begin
      in_target = !in_data_ff.dest_x[COORD_W-1] && !in_data_ff.dest_y[COORD_W-1] &&
                  ($signed({1'b0, in_data_ff.dest_x}) < $signed({3'b000, width_ff})) &&
                  ($signed({1'b0, in_data_ff.dest_y}) < $signed({3'b000, height_ff}));
      in_clip   = (in_data_ff.dest_x >= clip_left_ff) && (in_data_ff.dest_x < clip_right_ff) &&
                  (in_data_ff.dest_y >= clip_top_ff) && (in_data_ff.dest_y < clip_bottom_ff);
      blend_ctrl.mode      = in_mode_ff;
      blend_ctrl.in_bounds = in_target && in_clip;
   end

   gpb_blend u_blend (
      .ctrl          (blend_ctrl),
      .tint_colour   (tint_ff),
      .source_value  (in_data_ff.source_value),
      .dest_pixel    (in_data_ff.dest_pixel),
      .write_enable  (blend_we),
      .blended_pixel (blend_pixel)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pixel_ff <= blend_pixel;
         out_we_ff    <= blend_we;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tuser  = out_we_ff;

endmodule

// ===== rtl/gpb_blend.sv =====
`timescale 1ns / 1ps

module gpb_blend (
   input  gpb_pkg::blend_ctrl_type      ctrl,
   input  logic [gpb_pkg::PIX_W-1:0]    tint_colour,
   input  logic [gpb_pkg::PIX_W-1:0]    source_value,
   input  logic [gpb_pkg::PIX_W-1:0]    dest_pixel,
   output logic                         write_enable,
   output logic [gpb_pkg::PIX_W-1:0]    blended_pixel
);
   import gpb_pkg::*;

   logic [CHAN_W-1:0] alpha;
   logic [CHAN_W-1:0] inv_alpha;
   logic [CHAN_W-1:0] src_chan [NUM_CHAN];
   logic [CHAN_W:0]   chan_sum [NUM_CHAN];
   logic [PIX_W-1:0]  mixed;

   // Source alpha: the coverage for mono glyphs, the pixel alpha for emoji.
   always_comb begin
      if (ctrl.mode == MODE_MONO) begin
         alpha = source_value[CHAN_W-1:0];
      end else begin
         alpha = source_value[PIX_W-1 -: CHAN_W];
      end
      inv_alpha = CHAN_MAX - alpha;
   end

   // Per channel: source term plus scaled destination, saturating at full scale.
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         if (ctrl.mode == MODE_MONO) begin
            src_chan[i] = scale8(tint_colour[CHAN_W*i +: CHAN_W], alpha);
         end else begin
            src_chan[i] = source_value[CHAN_W*i +: CHAN_W];
         end
         chan_sum[i] = {1'b0, src_chan[i]} +
                       {1'b0, scale8(dest_pixel[CHAN_W*i +: CHAN_W], inv_alpha)};
         mixed[CHAN_W*i +: CHAN_W] = chan_sum[i][CHAN_W] ? CHAN_MAX
                                                         : chan_sum[i][CHAN_W-1:0];
      end
   end

   // Pixels that are clipped or fully transparent keep the destination value.
   assign write_enable  = ctrl.in_bounds && (alpha != '0);
   assign blended_pixel = write_enable ? mixed : dest_pixel;

endmodule

// ===== rtl/gpb_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A response beat never appears in the cycle after reset.
   `ASSERT_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")

   // A stalled response keeps its beat unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   // With the result register empty the block must take a request.
   `ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "request blocked with empty output")

endmodule

bind glyph_pixel_blend_core gpb_checker u_gpb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/glyph_pixel_blend_core_tb.sv =====
`timescale 1ns / 1ps

module glyph_pixel_blend_core_tb;
   import gpb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS  = 450;
   localparam int SEGMENT_ITEMS = 150;

   // One blended pixel as it leaves the block.
   typedef struct packed {
      logic             write_enable;
      logic [PIX_W-1:0] pixel;
   } blend_result_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [95:0]       req_tdata;   // dest_x, dest_y, source_value, dest_pixel
   logic              req_tuser;   // mode
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // blended_pixel
   logic              rsp_tuser;   // write_enable
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]       csr_data;

   // Shadow copy of the block's registers.
   logic [PIX_W-1:0]          tint_reg;
   logic [DIM_W-1:0]          width_reg;
   logic [DIM_W-1:0]          height_reg;
   logic signed [COORD_W-1:0] clip_left_reg;
   logic signed [COORD_W-1:0] clip_top_reg;
   logic signed [COORD_W-1:0] clip_right_reg;
   logic signed [COORD_W-1:0] clip_bottom_reg;

   blend_result_type pending_blends[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   glyph_pixel_blend_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Free-running clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // The response side stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Product of two channel values divided by 256, rounded to nearest.
   function automatic logic [7:0] mul_div256(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] wide;
      wide = a * b + 16'd128;
      return wide[15:8];
   endfunction

   // Source-over composite of one pixel against the shadow registers.
   function automatic blend_result_type blend_pixel(input mode_type mode,
                                                    input req_data_type beat);
      blend_result_type res;
      logic [7:0] alpha;
      logic [7:0] src_chan;
      logic [8:0] chan_sum;
      int         px;
      int         py;
      logic       in_area;
      px = int'(beat.dest_x);
      py = int'(beat.dest_y);
      in_area = px >= 0 && px < int'(width_reg) && py >= 0 && py < int'(height_reg) &&
                px >= clip_left_reg && px < clip_right_reg &&
                py >= clip_top_reg && py < clip_bottom_reg;
      alpha = (mode == MODE_MONO) ? beat.source_value[7:0] : beat.source_value[31:24];
      res.write_enable = in_area && alpha != 8'd0;
      res.pixel = beat.dest_pixel;
      if (res.write_enable) begin
         for (int c = 0; c < 4; c++) begin
            if (mode == MODE_MONO)
               src_chan = mul_div256(tint_reg[8*c +: 8], alpha);
            else
               src_chan = beat.source_value[8*c +: 8];
            chan_sum = src_chan + mul_div256(beat.dest_pixel[8*c +: 8], 8'd255 - alpha);
            res.pixel[8*c +: 8] = chan_sum[8] ? CHAN_MAX : chan_sum[7:0];
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Scoreboard: checks each response beat against the oldest prediction, then
   // records the prediction for a request beat accepted on the same edge.
   always @(posedge clock) begin
      blend_result_type got;
      blend_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.write_enable = rsp_tuser;
            got.pixel = rsp_tdata;
            if (pending_blends.size() == 0) begin
               note_mismatch($sformatf("unexpected beat we=%0b pixel=%08h",
                                       got.write_enable, got.pixel));
            end else begin
               want = pending_blends.pop_front();
               if (got.write_enable !== want.write_enable)
                  note_mismatch($sformatf("write_enable expected %0b, got %0b",
                                          want.write_enable, got.write_enable));
               if (got.pixel !== want.pixel)
                  note_mismatch($sformatf("blended_pixel expected %08h, got %08h",
                                          want.pixel, got.pixel));
            end
         end
         if (req_tvalid && req_tready)
            pending_blends.push_back(blend_pixel(mode_type'(req_tuser),
                                                 req_data_type'(req_tdata)));
      end
   end

   // Presents one pixel, with an occasional gap first, and waits for its acceptance.
   task automatic send_pixel(input mode_type mode, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic [31:0] src,
                             input logic [31:0] dst);
      req_data_type beat;
      beat.dest_x = x;
      beat.dest_y = y;
      beat.source_value = src;
      beat.dest_pixel = dst;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= beat;
      req_tuser <= mode;
      do @(posedge clock); while (!req_tready);
   endtask

   // Writes one register and mirrors it into the shadow copy.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TINT:        tint_reg = value;
         CSR_WIDTH:       width_reg = value[DIM_W-1:0];
         CSR_HEIGHT:      height_reg = value[DIM_W-1:0];
         CSR_CLIP_LEFT:   clip_left_reg = value[15:0];
         CSR_CLIP_TOP:    clip_top_reg = value[15:0];
         CSR_CLIP_RIGHT:  clip_right_reg = value[15:0];
         CSR_CLIP_BOTTOM: clip_bottom_reg = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds the request side off until every predicted beat has come back.
   task automatic drain_pixels();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sets target and clip in one go; the upper data bits carry random junk.
   task automatic set_window(input int w, input int h, input int l, input int t,
                             input int r, input int b);
      write_reg(CSR_WIDTH, {18'($urandom), 14'(w)});
      write_reg(CSR_HEIGHT, {18'($urandom), 14'(h)});
      write_reg(CSR_CLIP_LEFT, {16'($urandom), 16'(l)});
      write_reg(CSR_CLIP_TOP, {16'($urandom), 16'(t)});
      write_reg(CSR_CLIP_RIGHT, {16'($urandom), 16'(r)});
      write_reg(CSR_CLIP_BOTTOM, {16'($urandom), 16'(b)});
   endtask

   // After reset the target is empty, so nothing may be written.
   task automatic test_reset_state();
      send_pixel(MODE_EMOJI, 16'sd0, 16'sd0, 32'hFF80_4020, 32'h1234_5678);
      send_pixel(MODE_MONO, 16'sd0, 16'sd0, 32'h0000_00FF, 32'hCAFE_F00D);
      drain_pixels();
   endtask

   // Hand-picked pixels around the edges of the clip and of the arithmetic.
   task automatic test_directed_blends();
      write_reg(CSR_TINT, 32'h80C0_4020);
      set_window(16, 8, 2, 1, 12, 6);
      // Full, zero and partial coverage; the coverage ignores the upper source bits.
      send_pixel(MODE_MONO, 16'sd5, 16'sd3, 32'h0000_00FF, 32'h1122_3344);
      send_pixel(MODE_MONO, 16'sd5, 16'sd3, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      send_pixel(MODE_MONO, 16'sd5, 16'sd3, 32'hABCD_EF80, 32'h0000_0000);
      // Emoji with zero alpha, opaque, and channels that overflow.
      send_pixel(MODE_EMOJI, 16'sd5, 16'sd3, 32'h00FF_FFFF, 32'h1234_5678);
      send_pixel(MODE_EMOJI, 16'sd5, 16'sd3, 32'hFF10_2030, 32'hFFFF_FFFF);
      send_pixel(MODE_EMOJI, 16'sd5, 16'sd3, 32'h40FF_FFFF, 32'hFFFF_FFFF);
      // Each edge of the clip rectangle, and the coordinate extremes.
      send_pixel(MODE_EMOJI, -16'sd1, 16'sd3, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd1, 16'sd3, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd2, 16'sd1, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd11, 16'sd5, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd12, 16'sd3, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd5, 16'sd0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd5, 16'sd6, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sh7FFF, 16'sd3, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, -16'sh8000, -16'sh8000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd5, 16'sh7FFF, 32'hFFFF_FFFF, 32'h0000_0000);
      drain_pixels();
      // A transparent tint still scales the destination by the inverse of the coverage.
      write_reg(CSR_TINT, 32'h0000_0000);
      send_pixel(MODE_MONO, 16'sd5, 16'sd3, 32'h0000_0080, 32'hFFFF_FFFF);
      send_pixel(MODE_MONO, 16'sd5, 16'sd3, 32'h0000_0001, 32'h8080_8080);
      drain_pixels();
      // An inverted clip admits nothing.
      write_reg(CSR_CLIP_RIGHT, 32'h0000_0001);
      send_pixel(MODE_EMOJI, 16'sd1, 16'sd3, 32'hFFFF_FFFF, 32'h0101_0101);
      send_pixel(MODE_EMOJI, 16'sd5, 16'sd3, 32'hFFFF_FFFF, 32'h0101_0101);
      drain_pixels();
      // A target of zero width admits nothing, even under a full clip.
      set_window(0, 16383, -32768, -32768, 32767, 32767);
      send_pixel(MODE_EMOJI, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 32'h0101_0101);
      drain_pixels();
      // Largest target with the widest clip.
      write_reg(CSR_TINT, 32'hFFFF_FFFF);
      set_window(16383, 16383, -32768, -32768, 32767, 32767);
      send_pixel(MODE_MONO, 16'sd0, 16'sd0, 32'h0000_00FF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, 16'sd16382, 16'sd16382, 32'h8040_2010, 32'hFFFF_FFFF);
      send_pixel(MODE_EMOJI, 16'sd16383, 16'sd0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(MODE_EMOJI, -16'sd1, 16'sd0, 32'hFFFF_FFFF, 32'h0000_0000);
      drain_pixels();
   endtask

   // Picks a fresh tint, target and clip; mostly small windows, now and then an
   // extreme or an empty one.
   task automatic randomise_setup();
      int w;
      int h;
      int l;
      int t;
      w = $urandom_range(1, 64);
      h = $urandom_range(1, 64);
      l = int'($urandom_range(0, w)) - 4;
      t = int'($urandom_range(0, h)) - 4;
      write_reg(CSR_TINT, $urandom);
      case ($urandom_range(9))
         0: set_window(16383, 16383, -32768, -32768, 32767, 32767);
         1: set_window(w, h, l, t, l - int'($urandom_range(0, 3)), t + 4);
         2: set_window(w, 0, l, t, l + w, t + h);
         default: set_window(w, h, l, t, l + int'($urandom_range(1, w + 4)),
                             t + int'($urandom_range(1, h + 4)));
      endcase
   endtask

   // Random pixels, mostly around the current window, in several setups.
   task automatic test_random_pixels(input int idle_pct, input int stall_pct);
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [31:0] src;
      logic [31:0] dst;
      int pick;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % SEGMENT_ITEMS == 0) begin
            drain_pixels();
            randomise_setup();
         end
         if ($urandom_range(9) == 0) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else begin
            x = 16'(int'($urandom_range(0, int'(width_reg) + 8)) - 4);
            y = 16'(int'($urandom_range(0, int'(height_reg) + 8)) - 4);
         end
         src = $urandom;
         pick = $urandom_range(7);
         if (pick == 0) begin
            src[7:0] = 8'h00;
            src[31:24] = 8'h00;
         end else if (pick == 1) begin
            src[7:0] = 8'hFF;
            src[31:24] = 8'hFF;
         end
         dst = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
         send_pixel(mode_type'($urandom_range(1)), x, y, src, dst);
      end
      drain_pixels();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      tint_reg = TINT_RESET;
      width_reg = '0;
      height_reg = '0;
      clip_left_reg = '0;
      clip_top_reg = '0;
      clip_right_reg = '0;
      clip_bottom_reg = '0;
      send_idle_pct = 10;
      recv_stall_pct = 88;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_blends();
      test_random_pixels(10, 88);
      test_random_pixels(88, 10);
      test_random_pixels(0, 0);

      if (mismatch_count == 0 && pending_blends.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
